@@ src/rtte_pkg.sv @@
// shared types and constants for the retransmission timeout estimator
package rtte_pkg;

  localparam int unsigned TimeoutW  = 21;
  localparam int unsigned RttW      = 16;
  localparam int unsigned RetryW    = 3;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned OutDataW  = 48;

  localparam logic [TimeoutW-1:0] TimeoutMax  = 21'h1F_FFFF;
  localparam logic [TimeoutW-1:0] TimeoutHalf = 21'h0F_FFFF;
  localparam logic [RetryW-1:0]   RetryMax    = 3'd7;

  localparam logic [CfgW-1:0]   MinTimeoutRst  = 16'd1000;
  localparam logic [CfgW-1:0]   MaxTimeoutRst  = 16'd60000;
  localparam logic [CfgW-1:0]   InitTimeoutRst = 16'd3000;
  localparam logic [RetryW-1:0] RetryLimitRst  = 3'd5;

  typedef enum logic [1:0] {
    REQ_RESET   = 2'd0,
    REQ_SENT    = 2'd1,
    REQ_ACK     = 2'd2,
    REQ_TIMEOUT = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    REG_MIN_TIMEOUT  = 2'd0,
    REG_MAX_TIMEOUT  = 2'd1,
    REG_INIT_TIMEOUT = 2'd2,
    REG_RETRY_LIMIT  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0]   min_timeout;
    logic [CfgW-1:0]   max_timeout;
    logic [CfgW-1:0]   init_timeout;
    logic [RetryW-1:0] retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [RttW-1:0]     srtt;
    logic [RttW-1:0]     rttvar;
    logic [TimeoutW-1:0] timeout;
    logic [RetryW-1:0]   retries;
    logic                outstanding;
    logic                dead;
  } est_state_t;

  typedef struct packed {
    logic                gave_up;
    logic                do_retransmit;
    logic [RetryW-1:0]   retries_done;
    logic [RttW-1:0]     smoothed_rtt;
    logic [TimeoutW-1:0] timeout;
  } result_t;

endpackage

@@ src/rtte_cfg.sv @@
// apb configuration registers of the timeout estimator
module rtte_cfg import rtte_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_MIN_TIMEOUT:  cfg_d.min_timeout  = pwdata[CfgW-1:0];
        REG_MAX_TIMEOUT:  cfg_d.max_timeout  = pwdata[CfgW-1:0];
        REG_INIT_TIMEOUT: cfg_d.init_timeout = pwdata[CfgW-1:0];
        REG_RETRY_LIMIT:  cfg_d.retry_limit  = pwdata[RetryW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_TIMEOUT:  prdata = {16'd0, cfg_q.min_timeout};
      REG_MAX_TIMEOUT:  prdata = {16'd0, cfg_q.max_timeout};
      REG_INIT_TIMEOUT: prdata = {16'd0, cfg_q.init_timeout};
      REG_RETRY_LIMIT:  prdata = {29'd0, cfg_q.retry_limit};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_timeout  <= MinTimeoutRst;
      cfg_q.max_timeout  <= MaxTimeoutRst;
      cfg_q.init_timeout <= InitTimeoutRst;
      cfg_q.retry_limit  <= RetryLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ src/rtte_core.sv @@
// next-state and result logic for one estimator event
module rtte_core import rtte_pkg::*; (
  input  cfg_t            cfg_i,
  input  est_state_t      state_i,
  input  req_e            req_i,
  input  logic [RttW-1:0] sample_i,
  output est_state_t      state_o,
  output result_t         result_o
);

  logic [RttW-1:0]     diff;
  logic [RttW:0]       var_sum;
  logic [RttW:0]       srtt_sum;
  logic [RttW-1:0]     srtt_new;
  logic [RttW-1:0]     var_new;
  logic [RttW+2:0]     rto_raw;
  logic [RttW+2:0]     rto_lo;
  logic [RttW+2:0]     rto_hi;
  logic [RetryW:0]     retry_inc;
  logic [TimeoutW-1:0] timeout_dbl;
  logic                resend;
  logic                quit;

  // jacobson update with gains 1/8 and 1/4
  always_comb begin
    diff = (state_i.srtt >= sample_i) ? (state_i.srtt - sample_i)
                                      : (sample_i - state_i.srtt);
    var_sum  = {1'b0, state_i.rttvar} - {1'b0, state_i.rttvar >> 2} + {1'b0, diff >> 2};
    srtt_sum = {1'b0, state_i.srtt} - {1'b0, state_i.srtt >> 3} + {1'b0, sample_i >> 3};
    if (state_i.srtt == '0) begin
      srtt_new = sample_i;
      var_new  = sample_i >> 1;
    end else begin
      srtt_new = srtt_sum[RttW-1:0];
      var_new  = var_sum[RttW-1:0];
    end
    rto_raw = {3'd0, srtt_new} + {1'b0, var_new, 2'b00};
    rto_lo  = (rto_raw < {3'd0, cfg_i.min_timeout}) ? {3'd0, cfg_i.min_timeout} : rto_raw;
    rto_hi  = (rto_lo > {3'd0, cfg_i.max_timeout}) ? {3'd0, cfg_i.max_timeout} : rto_lo;
  end

  assign retry_inc   = {1'b0, state_i.retries} + 4'd1;
  assign timeout_dbl = (state_i.timeout > TimeoutHalf) ? TimeoutMax
                                                       : {state_i.timeout[TimeoutW-2:0], 1'b0};

  always_comb begin
    state_o = state_i;
    resend  = 1'b0;
    quit    = 1'b0;
    case (req_i)
      REQ_RESET: begin
        state_o.timeout     = {5'd0, cfg_i.init_timeout};
        state_o.srtt        = '0;
        state_o.rttvar      = '0;
        state_o.retries     = '0;
        state_o.outstanding = 1'b0;
        state_o.dead        = 1'b0;
      end
      REQ_SENT: begin
        if (!state_i.dead) begin
          state_o.outstanding = 1'b1;
          state_o.retries     = '0;
        end
      end
      REQ_ACK: begin
        if (!state_i.dead) begin
          state_o.outstanding = 1'b0;
          state_o.srtt        = srtt_new;
          state_o.rttvar      = var_new;
          state_o.timeout     = {5'd0, rto_hi[RttW-1:0]};
        end
      end
      REQ_TIMEOUT: begin
        if (!state_i.dead && state_i.outstanding) begin
          if (retry_inc > {1'b0, cfg_i.retry_limit}) begin
            quit                = 1'b1;
            state_o.dead        = 1'b1;
            state_o.outstanding = 1'b0;
            state_o.retries     = retry_inc[RetryW] ? RetryMax : retry_inc[RetryW-1:0];
          end else begin
            resend          = 1'b1;
            state_o.retries = retry_inc[RetryW-1:0];
            state_o.timeout = timeout_dbl;
          end
        end
      end
      default: state_o = state_i;
    endcase
  end

  assign result_o.timeout       = state_o.timeout;
  assign result_o.smoothed_rtt  = state_o.srtt;
  assign result_o.retries_done  = state_o.retries;
  assign result_o.do_retransmit = resend;
  assign result_o.gave_up       = quit;

endmodule

@@ src/rtt_estimator_retransmit_backoff.sv @@
// top level of the retransmission timeout estimator
// path: input transaction registers, then result registers on the master side
// throughput: one event per cycle while m_axis_tready holds; the state update
// runs through the shift-and-add core between input and result registers
// reset: asynchronous active low; registers return to their defaults and the
// estimator state to an unprimed estimate with the initial timeout
module rtt_estimator_retransmit_backoff import rtte_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [RttW-1:0]      s_axis_tdata,   // rtt_sample_ms
  input  logic [1:0]           s_axis_tuser,   // req_type
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // timeout_ms, smoothed_rtt_ms, retries_done, do_retransmit, gave_up, zero pad
  output logic [OutDataW-1:0]  m_axis_tdata,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrW-1:0]     paddr,
  input  logic [ApbDataW-1:0]  pwdata,
  output logic [ApbDataW-1:0]  prdata,
  output logic                 pready
);

  cfg_t            cfg;
  est_state_t      state_q, state_d;
  result_t         res_d, res_q;
  logic            in_vld_q;
  req_e            req_q;
  logic [RttW-1:0] sample_q;
  logic            out_vld_q;
  logic            advance;

  rtte_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rtte_core u_core (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .req_i    (req_q),
    .sample_i (sample_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q.srtt        <= '0;
      state_q.rttvar      <= '0;
      state_q.timeout     <= {5'd0, InitTimeoutRst};
      state_q.retries     <= '0;
      state_q.outstanding <= 1'b0;
      state_q.dead        <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
      if (in_vld_q && advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q    <= req_e'(s_axis_tuser);
      sample_q <= s_axis_tdata;
    end
    if (in_vld_q && advance) begin
      res_q <= res_d;
    end
  end

endmodule

@@ tb/tb_rtt_estimator_retransmit_backoff.sv @@
// testbench for the retransmission timeout estimator: predicted results checked per transaction
`timescale 1ns / 100ps

module tb_rtt_estimator_retransmit_backoff;
  import rtte_pkg::*;

  typedef struct packed {
    req_e            kind;
    logic [RttW-1:0] sample;
  } rto_req_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [RttW-1:0]     s_axis_tdata = '0;  // rtt_sample_ms
  logic [1:0]          s_axis_tuser = '0;  // req_type
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // timeout_ms, smoothed_rtt_ms, retries_done, do_retransmit, gave_up, zero pad
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  rto_req_t pending_events[$];
  result_t  expected_results[$];
  rto_req_t on_bus;
  int       errors = 0;
  logic     no_idle = 1'b0;
  logic [RetryW-1:0] gen_limit = RetryLimitRst;

  logic [CfgW-1:0]     cfg_min = MinTimeoutRst;
  logic [CfgW-1:0]     cfg_max = MaxTimeoutRst;
  logic [CfgW-1:0]     cfg_init = InitTimeoutRst;
  logic [RetryW-1:0]   cfg_limit = RetryLimitRst;

  logic [RttW-1:0]     est_srtt = '0;
  logic [RttW-1:0]     est_var = '0;
  logic [TimeoutW-1:0] est_tmo = InitTimeoutRst;
  logic [RetryW-1:0]   est_tries = '0;
  logic                est_out = 1'b0;
  logic                est_dead = 1'b0;

  rtt_estimator_retransmit_backoff i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic result_t advance_estimator(input rto_req_t rq);
    result_t     r;
    logic [31:0] diff;
    logic [31:0] v32;
    logic [31:0] s32;
    logic [31:0] rto;
    logic [3:0]  next_try;
    r = '0;
    if (rq.kind == REQ_RESET) begin
      est_tmo   = {5'b0, cfg_init};
      est_srtt  = '0;
      est_var   = '0;
      est_tries = '0;
      est_out   = 1'b0;
      est_dead  = 1'b0;
    end else if (!est_dead) begin
      if (rq.kind == REQ_SENT) begin
        est_out   = 1'b1;
        est_tries = '0;
      end else if (rq.kind == REQ_ACK) begin
        est_out = 1'b0;
        if (est_srtt == '0) begin
          est_srtt = rq.sample;
          est_var  = rq.sample >> 1;
        end else begin
          diff = (est_srtt >= rq.sample) ? 32'(est_srtt - rq.sample)
                                         : 32'(rq.sample - est_srtt);
          v32 = 32'(est_var) - 32'(est_var >> 2) + (diff >> 2);
          s32 = 32'(est_srtt) - 32'(est_srtt >> 3) + 32'(rq.sample >> 3);
          est_var  = v32[15:0];
          est_srtt = s32[15:0];
        end
        rto = 32'(est_srtt) + (32'(est_var) << 2);
        if (rto < 32'(cfg_min)) rto = 32'(cfg_min);
        if (rto > 32'(cfg_max)) rto = 32'(cfg_max);
        est_tmo = rto[TimeoutW-1:0];
      end else if (est_out) begin
        next_try = {1'b0, est_tries} + 4'd1;
        if (next_try > {1'b0, cfg_limit}) begin
          r.gave_up = 1'b1;
          est_dead  = 1'b1;
          est_out   = 1'b0;
          est_tries = (next_try > 4'd7) ? RetryMax : next_try[2:0];
        end else begin
          est_tries = next_try[2:0];
          est_tmo   = (est_tmo > TimeoutHalf) ? TimeoutMax : (est_tmo << 1);
          r.do_retransmit = 1'b1;
        end
      end
    end
    r.timeout      = est_tmo;
    r.smoothed_rtt = est_srtt;
    r.retries_done = est_tries;
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(advance_estimator(on_bus));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_events.size() != 0 && (no_idle || $urandom_range(99) >= 11)) begin
          on_bus = pending_events.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= on_bus.sample;
          s_axis_tuser  <= on_bus.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= 11);
  end

  // register writes as seen by the predictor
  always @(posedge clk_i) begin
    if (psel && penable && pwrite && pready) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_MIN_TIMEOUT:  cfg_min   = pwdata[CfgW-1:0];
        REG_MAX_TIMEOUT:  cfg_max   = pwdata[CfgW-1:0];
        REG_INIT_TIMEOUT: cfg_init  = pwdata[CfgW-1:0];
        REG_RETRY_LIMIT:  cfg_limit = pwdata[RetryW-1:0];
        default: ;
      endcase
    end
  end

  // monitor
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      if (expected_results.size() == 0) begin
        $error("result transaction with no expectation pending");
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.timeout !== want.timeout) begin
          $error("timeout_ms expected %0d got %0d", want.timeout, got.timeout);
          errors++;
        end
        if (got.smoothed_rtt !== want.smoothed_rtt) begin
          $error("smoothed_rtt_ms expected %0d got %0d", want.smoothed_rtt, got.smoothed_rtt);
          errors++;
        end
        if (got.retries_done !== want.retries_done) begin
          $error("retries_done expected %0d got %0d", want.retries_done, got.retries_done);
          errors++;
        end
        if (got.do_retransmit !== want.do_retransmit) begin
          $error("do_retransmit expected %0d got %0d", want.do_retransmit, got.do_retransmit);
          errors++;
        end
        if (got.gave_up !== want.gave_up) begin
          $error("gave_up expected %0d got %0d", want.gave_up, got.gave_up);
          errors++;
        end
      end
    end
  end

  task automatic add_event(input req_e kind, input logic [RttW-1:0] sample);
    rto_req_t rq;
    rq.kind   = kind;
    rq.sample = sample;
    pending_events.push_back(rq);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [CfgW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'b0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [CfgW-1:0] lo, input logic [CfgW-1:0] hi,
                            input logic [CfgW-1:0] init, input logic [RetryW-1:0] lim);
    reg_write(REG_MIN_TIMEOUT, lo);
    reg_write(REG_MAX_TIMEOUT, hi);
    reg_write(REG_INIT_TIMEOUT, init);
    reg_write(REG_RETRY_LIMIT, {13'b0, lim});
    gen_limit = lim;
  endtask

  task automatic wait_idle();
    while (pending_events.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  function automatic logic [RttW-1:0] pick_sample();
    case ($urandom_range(3))
      0: return 16'($urandom_range(255));
      1: return 16'($urandom_range(4000));
      2: return 16'($urandom_range(65535));
      default: return ($urandom_range(3) == 0) ? 16'h0 : 16'hFFFF - 16'($urandom_range(15));
    endcase
  endfunction

  // mostly sent / timeouts / ack sequences, with some loose transactions mixed in
  task automatic fill_random(input int n_items);
    int count;
    int tmo_cnt;
    count = 0;
    while (count < n_items) begin
      if ($urandom_range(99) < 15) begin
        add_event(req_e'($urandom_range(3)), 16'($urandom_range(65535)));
        count++;
      end else begin
        if ($urandom_range(9) == 0) begin
          add_event(REQ_RESET, 16'($urandom_range(65535)));
          count++;
        end
        add_event(REQ_SENT, 16'($urandom_range(65535)));
        tmo_cnt = ($urandom_range(3) == 0) ? $urandom_range(8) : $urandom_range(2);
        repeat (tmo_cnt) add_event(REQ_TIMEOUT, 16'($urandom_range(65535)));
        add_event(REQ_ACK, pick_sample());
        count += tmo_cnt + 2;
        if (tmo_cnt > gen_limit) begin
          add_event(REQ_RESET, 16'($urandom_range(65535)));
          count++;
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // defaults after reset
    add_event(REQ_RESET, 16'hFFFF);
    add_event(REQ_TIMEOUT, 16'h0);
    add_event(REQ_ACK, 16'h0);
    add_event(REQ_ACK, 16'hFFFF);
    add_event(REQ_ACK, 16'h0);
    add_event(REQ_ACK, 16'hFFFF);
    add_event(REQ_SENT, 16'h5A5A);
    add_event(REQ_SENT, 16'hA5A5);
    repeat (6) add_event(REQ_TIMEOUT, 16'h0);
    add_event(REQ_TIMEOUT, 16'h1234);
    add_event(REQ_SENT, 16'h0);
    add_event(REQ_ACK, 16'd700);
    add_event(REQ_RESET, 16'h0);
    add_event(REQ_ACK, 16'd200);
    add_event(REQ_SENT, 16'h0);
    add_event(REQ_TIMEOUT, 16'hFFFF);
    add_event(REQ_ACK, 16'd180);
    fill_random(150);
    wait_idle();

    // widest bounds, backoff saturation and retry count saturation
    set_config(16'd0, 16'hFFFF, 16'hFFFF, 3'd7);
    add_event(REQ_RESET, 16'h0);
    add_event(REQ_ACK, 16'hFFFF);
    add_event(REQ_SENT, 16'h0);
    repeat (8) add_event(REQ_TIMEOUT, 16'h0);
    add_event(REQ_RESET, 16'h0);
    fill_random(200);
    wait_idle();

    // min above max, zero initial timeout, no retries allowed
    set_config(16'hFFFF, 16'd0, 16'd0, 3'd0);
    add_event(REQ_RESET, 16'h0);
    add_event(REQ_ACK, 16'd500);
    add_event(REQ_SENT, 16'h0);
    add_event(REQ_TIMEOUT, 16'h0);
    add_event(REQ_RESET, 16'h0);
    fill_random(200);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) begin
        no_idle = 1'b1;
      end
      if (ph == 2) begin
        set_config(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   16'($urandom_range(65535)), 3'($urandom_range(7)));
      end else begin
        set_config(16'($urandom_range(3000)), 16'($urandom_range(65535, 2000)),
                   16'($urandom_range(65535)), 3'($urandom_range(7)));
      end
      add_event(REQ_RESET, 16'($urandom_range(65535)));
      fill_random(210);
      wait_idle();
    end

    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
